[sv/cup_weight_drink_tracker_unit_assert.svh]
// Assertion macros used by the tracker back stage.
`ifndef CUP_WEIGHT_DRINK_TRACKER_UNIT_ASSERT_SVH
`define CUP_WEIGHT_DRINK_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define CWDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cwdt assertion failed");

// next-cycle implication
`define CWDT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cwdt assertion failed");

`endif

[sv/cwdt_pkg.sv]
// Types and constants of the cup weight drink tracker.
package cwdt_pkg;

    localparam int W_WEIGHT = 25;
    localparam int W_LEVEL  = 24;
    localparam int W_TOTAL  = 27;
    localparam int W_REM    = 19;
    localparam int W_TARE   = 19;
    localparam int W_CNT    = 2;
    localparam int W_GOAL   = 13;
    localparam int W_TOL    = 14;
    localparam int W_DELTA  = 14;
    localparam int W_KIND   = 3;
    localparam int W_OP     = 3;
    localparam int W_EV     = 3;
    localparam int W_CFG_IDX  = 2;
    localparam int W_CFG_DATA = 14;
    localparam int W_S_TDATA  = 32;
    localparam int W_M_TDATA  = 128;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [W_CNT-1:0] STABLE_SAMPLES = 2'd3;

    localparam logic [W_KIND-1:0] KIND_SAMPLE = 3'd0;
    localparam logic [W_KIND-1:0] KIND_FAIL   = 3'd1;
    localparam logic [W_KIND-1:0] KIND_CUP    = 3'd2;
    localparam logic [W_KIND-1:0] KIND_BASE   = 3'd3;
    localparam logic [W_KIND-1:0] KIND_DAY    = 3'd4;

    localparam logic [W_OP-1:0] OP_SAMPLE = 3'd0;
    localparam logic [W_OP-1:0] OP_FAIL   = 3'd1;
    localparam logic [W_OP-1:0] OP_CUP    = 3'd2;
    localparam logic [W_OP-1:0] OP_BASE   = 3'd3;
    localparam logic [W_OP-1:0] OP_DAY    = 3'd4;
    localparam logic [W_OP-1:0] OP_IGNORE = 3'd5;

    localparam logic [W_EV-1:0] EV_NONE   = 3'd0;
    localparam logic [W_EV-1:0] EV_DRINK  = 3'd1;
    localparam logic [W_EV-1:0] EV_REFILL = 3'd2;
    localparam logic [W_EV-1:0] EV_FIRST  = 3'd3;
    localparam logic [W_EV-1:0] EV_REJECT = 3'd4;

    localparam logic [W_CFG_IDX-1:0] CFG_GOAL  = 2'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_TOL   = 2'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_DELTA = 2'd2;

    localparam logic signed [W_WEIGHT-1:0] CUP_MIN_CG = 25'sd100;
    localparam logic signed [W_WEIGHT-1:0] CUP_MAX_CG = 25'sd500000;
    localparam logic [W_LEVEL-1:0]  LEVEL_MAX    = 24'd10000000;
    localparam logic [W_TOTAL-1:0]  TOTAL_MAX    = 27'd100000000;
    localparam logic [W_GOAL-1:0]   GOAL_DEFAULT = 13'd1500;
    localparam logic [W_GOAL-1:0]   GOAL_MAX     = 13'd5000;
    localparam logic [W_TOL-1:0]    TOL_RESET    = 14'd500;
    localparam logic [W_DELTA-1:0]  DELTA_RESET  = 14'd200;
    localparam logic [W_REM:0]      CG_PER_ML    = 20'd100;

    typedef struct packed {
        logic [W_OP-1:0]            op;
        logic                       cup_in_range;
        logic signed [W_WEIGHT-1:0] weight;
    } item_t;

    typedef struct packed {
        logic [W_GOAL-1:0]  goal_ml;
        logic [W_TOL-1:0]   tol_cg;
        logic [W_DELTA-1:0] jitter_cg;
    } cfg_t;

    typedef struct packed {
        logic               scale_ready;
        logic               cup_present;
        logic [W_LEVEL-1:0] water;
        logic [W_LEVEL-1:0] base_water;
        logic               base_valid;
        logic [W_TOTAL-1:0] total;
        logic [W_EV-1:0]    ev;
        logic [W_LEVEL-1:0] drink;
    } exec_t;

endpackage

[sv/cwdt_front.sv]
// Front stage: accept scale transactions and classify them.
module cwdt_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cwdt_pkg::W_KIND-1:0]    kind,
    input  logic signed [cwdt_pkg::W_WEIGHT-1:0] weight,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cwdt_pkg::item_t                out_item
);

    logic            valid_reg;
    cwdt_pkg::item_t item_reg;
    cwdt_pkg::item_t item_next;

    always_comb begin
        item_next.weight       = weight;
        item_next.cup_in_range = (weight >= cwdt_pkg::CUP_MIN_CG) &&
                                 (weight <= cwdt_pkg::CUP_MAX_CG);
        unique case (kind)
            cwdt_pkg::KIND_SAMPLE: item_next.op = cwdt_pkg::OP_SAMPLE;
            cwdt_pkg::KIND_FAIL:   item_next.op = cwdt_pkg::OP_FAIL;
            cwdt_pkg::KIND_CUP:    item_next.op = cwdt_pkg::OP_CUP;
            cwdt_pkg::KIND_BASE:   item_next.op = cwdt_pkg::OP_BASE;
            cwdt_pkg::KIND_DAY:    item_next.op = cwdt_pkg::OP_DAY;
            default:               item_next.op = cwdt_pkg::OP_IGNORE;
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

[sv/cwdt_queue.sv]
// Two-entry queue between the front and the back stage.
module cwdt_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  cwdt_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output cwdt_pkg::item_t pop_item
);

    cwdt_pkg::item_t                 entry_reg [cwdt_pkg::QDEPTH];
    logic [cwdt_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [cwdt_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [cwdt_pkg::QCNT_W-1:0]     count_reg;
    logic [cwdt_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [cwdt_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [cwdt_pkg::QCNT_W-1:0]     count_next;
    logic                            push;
    logic                            pop;

    assign push_ready = count_reg < cwdt_pkg::QCNT_W'(cwdt_pkg::QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == cwdt_pkg::QPTR_W'(cwdt_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == cwdt_pkg::QPTR_W'(cwdt_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[sv/cwdt_back.sv]
// Back stage: update cup, level and daily total state for each transaction.
`include "cup_weight_drink_tracker_unit_assert.svh"

module cwdt_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [cwdt_pkg::W_TOL-1:0]     tol_cg,
    input  logic [cwdt_pkg::W_DELTA-1:0]   jitter_cg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cwdt_pkg::item_t                in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cwdt_pkg::exec_t                out_res
);

    logic [cwdt_pkg::W_TARE-1:0]  tare_reg,       tare_next;
    logic                         tare_valid_reg, tare_valid_next;
    logic [cwdt_pkg::W_LEVEL-1:0] base_water_reg, base_water_next;
    logic                         base_valid_reg, base_valid_next;
    logic                         reading_ok_reg, reading_ok_next;
    logic signed [cwdt_pkg::W_WEIGHT-1:0] last_reg, last_next;
    logic [cwdt_pkg::W_LEVEL-1:0] cand_reg,       cand_next;
    logic                         cand_valid_reg, cand_valid_next;
    logic [cwdt_pkg::W_CNT-1:0]   cnt_reg,        cnt_next;
    logic [cwdt_pkg::W_LEVEL-1:0] stable_reg,     stable_next;
    logic                         stable_valid_reg, stable_valid_next;
    logic [cwdt_pkg::W_TOTAL-1:0] total_reg,      total_next;
    logic                         res_valid_reg;
    cwdt_pkg::exec_t              res_reg,        res_next;

    logic signed [cwdt_pkg::W_TARE:0]     thr;
    logic [cwdt_pkg::W_TARE-1:0]          thr0;
    logic                                 present_w;
    logic signed [cwdt_pkg::W_WEIGHT:0]   wdiff;
    logic [cwdt_pkg::W_LEVEL-1:0]         water_raw;
    logic [cwdt_pkg::W_LEVEL-1:0]         water_w;
    logic [cwdt_pkg::W_LEVEL-1:0]         bwater_w;
    logic                                 present_l;
    logic signed [cwdt_pkg::W_WEIGHT:0]   ldiff;
    logic [cwdt_pkg::W_LEVEL-1:0]         water_l;
    logic                                 pres_out;
    logic [cwdt_pkg::W_LEVEL-1:0]         water_out;
    logic signed [cwdt_pkg::W_LEVEL:0]    cdiff;
    logic signed [cwdt_pkg::W_LEVEL:0]    cdiff_neg;
    logic [cwdt_pkg::W_LEVEL-1:0]         cabs;
    logic                                 cand_far;
    logic [cwdt_pkg::W_CNT-1:0]           cnt_inc;
    logic signed [cwdt_pkg::W_LEVEL:0]    sdiff;
    logic signed [cwdt_pkg::W_LEVEL:0]    sdiff_neg;
    logic [cwdt_pkg::W_LEVEL-1:0]         sabs;
    logic                                 stable_far;
    logic [cwdt_pkg::W_TOTAL:0]           sum;
    logic [cwdt_pkg::W_TOTAL-1:0]         total_add;
    logic [cwdt_pkg::W_EV-1:0]            ev;
    logic [cwdt_pkg::W_LEVEL-1:0]         drink;
    logic                                 fire;

    assign in_ready  = !res_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        thr  = $signed({1'b0, tare_reg}) -
               $signed({{(cwdt_pkg::W_TARE - cwdt_pkg::W_TOL + 1){1'b0}}, tol_cg});
        thr0 = thr[cwdt_pkg::W_TARE] ? '0 : thr[cwdt_pkg::W_TARE-1:0];
        present_w = tare_valid_reg &&
                    (in_item.weight >=
                     $signed({{(cwdt_pkg::W_WEIGHT - cwdt_pkg::W_TARE){1'b0}}, thr0}));
        wdiff = $signed({in_item.weight[cwdt_pkg::W_WEIGHT-1], in_item.weight}) -
                $signed({{(cwdt_pkg::W_WEIGHT + 1 - cwdt_pkg::W_TARE){1'b0}}, tare_reg});
        bwater_w = wdiff[cwdt_pkg::W_WEIGHT] ? '0 : wdiff[cwdt_pkg::W_LEVEL-1:0];
        if (wdiff[cwdt_pkg::W_WEIGHT]) begin
            water_raw = '0;
        end else if (wdiff > $signed({2'b00, cwdt_pkg::LEVEL_MAX})) begin
            water_raw = cwdt_pkg::LEVEL_MAX;
        end else begin
            water_raw = wdiff[cwdt_pkg::W_LEVEL-1:0];
        end
        water_w = present_w ? water_raw : '0;

        present_l = tare_valid_reg && reading_ok_reg &&
                    (last_reg >=
                     $signed({{(cwdt_pkg::W_WEIGHT - cwdt_pkg::W_TARE){1'b0}}, thr0}));
        ldiff = $signed({last_reg[cwdt_pkg::W_WEIGHT-1], last_reg}) -
                $signed({{(cwdt_pkg::W_WEIGHT + 1 - cwdt_pkg::W_TARE){1'b0}}, tare_reg});
        if (!present_l || ldiff[cwdt_pkg::W_WEIGHT]) begin
            water_l = '0;
        end else if (ldiff > $signed({2'b00, cwdt_pkg::LEVEL_MAX})) begin
            water_l = cwdt_pkg::LEVEL_MAX;
        end else begin
            water_l = ldiff[cwdt_pkg::W_LEVEL-1:0];
        end

        cdiff     = $signed({1'b0, water_w}) - $signed({1'b0, cand_reg});
        cdiff_neg = -cdiff;
        cabs      = cdiff[cwdt_pkg::W_LEVEL] ? cdiff_neg[cwdt_pkg::W_LEVEL-1:0] :
                                               cdiff[cwdt_pkg::W_LEVEL-1:0];
        cand_far  = cabs > {{(cwdt_pkg::W_LEVEL - cwdt_pkg::W_DELTA){1'b0}}, jitter_cg};
        cnt_inc   = (cnt_reg < cwdt_pkg::STABLE_SAMPLES) ? cnt_reg + 1'b1 : cnt_reg;

        sdiff      = $signed({1'b0, stable_reg}) - $signed({1'b0, cand_reg});
        sdiff_neg  = -sdiff;
        sabs       = sdiff[cwdt_pkg::W_LEVEL] ? sdiff_neg[cwdt_pkg::W_LEVEL-1:0] :
                                                sdiff[cwdt_pkg::W_LEVEL-1:0];
        stable_far = sabs > {{(cwdt_pkg::W_LEVEL - cwdt_pkg::W_DELTA){1'b0}}, jitter_cg};
        sum        = {1'b0, total_reg} +
                     {{(cwdt_pkg::W_TOTAL + 1 - cwdt_pkg::W_LEVEL){1'b0}},
                      sdiff[cwdt_pkg::W_LEVEL-1:0]};
        total_add  = (sum > {1'b0, cwdt_pkg::TOTAL_MAX}) ? cwdt_pkg::TOTAL_MAX :
                                                           sum[cwdt_pkg::W_TOTAL-1:0];
    end

    always_comb begin
        tare_next         = tare_reg;
        tare_valid_next   = tare_valid_reg;
        base_water_next   = base_water_reg;
        base_valid_next   = base_valid_reg;
        reading_ok_next   = reading_ok_reg;
        last_next         = last_reg;
        pres_out          = present_l;
        water_out         = water_l;
        cand_next         = cand_reg;
        cand_valid_next   = cand_valid_reg;
        cnt_next          = cnt_reg;
        stable_next       = stable_reg;
        stable_valid_next = stable_valid_reg;
        total_next        = total_reg;
        ev                = cwdt_pkg::EV_NONE;
        drink             = '0;

        unique case (in_item.op)
            cwdt_pkg::OP_SAMPLE: begin
                reading_ok_next = 1'b1;
                last_next       = in_item.weight;
                pres_out        = present_w;
                water_out       = water_w;
                if (present_w) begin
                    if (!cand_valid_reg || cand_far) begin
                        cand_next       = water_w;
                        cand_valid_next = 1'b1;
                        cnt_next        = cwdt_pkg::W_CNT'(1);
                    end else begin
                        cnt_next = cnt_inc;
                        if (cnt_inc >= cwdt_pkg::STABLE_SAMPLES) begin
                            if (!stable_valid_reg) begin
                                stable_next       = cand_reg;
                                stable_valid_next = 1'b1;
                                ev                = cwdt_pkg::EV_FIRST;
                            end else if (stable_far) begin
                                stable_next = cand_reg;
                                if (!sdiff[cwdt_pkg::W_LEVEL]) begin
                                    total_next = total_add;
                                    drink      = sdiff[cwdt_pkg::W_LEVEL-1:0];
                                    ev         = cwdt_pkg::EV_DRINK;
                                end else begin
                                    ev = cwdt_pkg::EV_REFILL;
                                end
                            end
                        end
                    end
                end
            end
            cwdt_pkg::OP_FAIL: begin
                reading_ok_next = 1'b0;
                pres_out        = 1'b0;
                water_out       = '0;
            end
            cwdt_pkg::OP_CUP: begin
                if (!in_item.cup_in_range) begin
                    ev = cwdt_pkg::EV_REJECT;
                end else begin
                    reading_ok_next   = 1'b1;
                    last_next         = in_item.weight;
                    tare_next         = in_item.weight[cwdt_pkg::W_TARE-1:0];
                    tare_valid_next   = 1'b1;
                    base_valid_next   = 1'b0;
                    base_water_next   = '0;
                    pres_out          = 1'b1;
                    water_out         = '0;
                    cand_next         = '0;
                    cand_valid_next   = 1'b1;
                    cnt_next          = cwdt_pkg::STABLE_SAMPLES;
                    stable_next       = '0;
                    stable_valid_next = 1'b1;
                end
            end
            cwdt_pkg::OP_BASE: begin
                if (!tare_valid_reg) begin
                    ev = cwdt_pkg::EV_REJECT;
                end else begin
                    reading_ok_next   = 1'b1;
                    last_next         = in_item.weight;
                    base_valid_next   = 1'b1;
                    base_water_next   = bwater_w;
                    pres_out          = present_w;
                    water_out         = water_w;
                    cand_next         = water_w;
                    cand_valid_next   = 1'b1;
                    cnt_next          = cwdt_pkg::STABLE_SAMPLES;
                    stable_next       = water_w;
                    stable_valid_next = 1'b1;
                end
            end
            cwdt_pkg::OP_DAY: begin
                total_next        = '0;
                stable_next       = '0;
                stable_valid_next = 1'b0;
                cand_next         = '0;
                cand_valid_next   = 1'b0;
                cnt_next          = '0;
            end
            default: begin
            end
        endcase

        res_next.scale_ready = reading_ok_next;
        res_next.cup_present = pres_out;
        res_next.water       = water_out;
        res_next.base_water  = base_water_next;
        res_next.base_valid  = base_valid_next;
        res_next.total       = total_next;
        res_next.ev          = ev;
        res_next.drink       = drink;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tare_reg         <= '0;
            tare_valid_reg   <= 1'b0;
            base_water_reg   <= '0;
            base_valid_reg   <= 1'b0;
            reading_ok_reg   <= 1'b0;
            last_reg         <= '0;
            cand_reg         <= '0;
            cand_valid_reg   <= 1'b0;
            cnt_reg          <= '0;
            stable_reg       <= '0;
            stable_valid_reg <= 1'b0;
            total_reg        <= '0;
        end else if (fire) begin
            tare_reg         <= tare_next;
            tare_valid_reg   <= tare_valid_next;
            base_water_reg   <= base_water_next;
            base_valid_reg   <= base_valid_next;
            reading_ok_reg   <= reading_ok_next;
            last_reg         <= last_next;
            cand_reg         <= cand_next;
            cand_valid_reg   <= cand_valid_next;
            cnt_reg          <= cnt_next;
            stable_reg       <= stable_next;
            stable_valid_reg <= stable_valid_next;
            total_reg        <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (in_ready) begin
            res_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    `CWDT_ASSERT_IMP(a_cnt_range, aclk, aresetn, 1'b1, cnt_reg <= cwdt_pkg::STABLE_SAMPLES)
    `CWDT_ASSERT_IMP(a_total_cap, aclk, aresetn, 1'b1, total_reg <= cwdt_pkg::TOTAL_MAX)
    `CWDT_ASSERT_IMP(a_base_needs_tare, aclk, aresetn, base_valid_reg, tare_valid_reg)
    `CWDT_ASSERT_IMP(a_drink_event, aclk, aresetn, res_valid_reg && (res_reg.drink != '0), res_reg.ev == cwdt_pkg::EV_DRINK)
    `CWDT_ASSERT_NXT(a_res_hold, aclk, aresetn, res_valid_reg && !out_ready, res_valid_reg && $stable(res_reg))

endmodule

[sv/cwdt_out.sv]
// Output stage: derive session, goal fields and register the result transaction.
module cwdt_out (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [cwdt_pkg::W_GOAL-1:0]      goal_ml,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  cwdt_pkg::exec_t                  in_res,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cwdt_pkg::W_M_TDATA-1:0]   m_tdata,
    output logic [cwdt_pkg::W_EV-1:0]        m_tuser
);

    localparam int W_USED = 1 + 1 + cwdt_pkg::W_LEVEL + cwdt_pkg::W_LEVEL +
                            cwdt_pkg::W_TOTAL + cwdt_pkg::W_REM + 1 + cwdt_pkg::W_LEVEL;

    logic                                valid_reg;
    logic [cwdt_pkg::W_M_TDATA-1:0]      data_reg, data_next;
    logic [cwdt_pkg::W_EV-1:0]           user_reg;
    logic [cwdt_pkg::W_GOAL-1:0]         goal_sel;
    logic [cwdt_pkg::W_REM:0]            goal_prod;
    logic [cwdt_pkg::W_REM-1:0]          goal_cg;
    logic signed [cwdt_pkg::W_LEVEL:0]   bdiff;
    logic [cwdt_pkg::W_LEVEL-1:0]        consumed;
    logic [cwdt_pkg::W_REM-1:0]          remaining;
    logic                                goal_met;

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    always_comb begin
        if (goal_ml == '0) begin
            goal_sel = cwdt_pkg::GOAL_DEFAULT;
        end else if (goal_ml > cwdt_pkg::GOAL_MAX) begin
            goal_sel = cwdt_pkg::GOAL_MAX;
        end else begin
            goal_sel = goal_ml;
        end
        goal_prod = {{(cwdt_pkg::W_REM + 1 - cwdt_pkg::W_GOAL){1'b0}}, goal_sel} *
                    cwdt_pkg::CG_PER_ML;
        goal_cg   = goal_prod[cwdt_pkg::W_REM-1:0];

        bdiff = $signed({1'b0, in_res.base_water}) - $signed({1'b0, in_res.water});
        if (!in_res.base_valid || bdiff[cwdt_pkg::W_LEVEL]) begin
            consumed = '0;
        end else if (bdiff > $signed({1'b0, cwdt_pkg::LEVEL_MAX})) begin
            consumed = cwdt_pkg::LEVEL_MAX;
        end else begin
            consumed = bdiff[cwdt_pkg::W_LEVEL-1:0];
        end

        goal_met  = in_res.total >= {{(cwdt_pkg::W_TOTAL - cwdt_pkg::W_REM){1'b0}}, goal_cg};
        remaining = goal_met ? '0 : goal_cg - in_res.total[cwdt_pkg::W_REM-1:0];

        data_next = {{(cwdt_pkg::W_M_TDATA - W_USED){1'b0}},
                     in_res.drink, goal_met, remaining, in_res.total,
                     consumed, in_res.water, in_res.cup_present, in_res.scale_ready};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
            user_reg <= in_res.ev;
        end
    end

endmodule

[sv/cup_weight_drink_tracker_unit.sv]
// Top level of the cup weight drink tracker.
// Usage:
//   s_ channel: one scale transaction per handshake; s_tuser carries the event kind
//   (sample, read failed, capture empty cup, capture baseline, new day) and s_tdata
//   the signed weight in centigrams.
//   m_ channel: exactly one result transaction per input transaction, in order;
//   m_tuser carries the event code, m_tdata the status after that transaction.
//   cfg_ port: write goal, cup tolerance and stable delta while the block is idle;
//   writes take effect at the clock edge, no read-back.
// Timing: a transaction, taken at the accepting edge, passes the front register, the queue,
//   the state update and the output register before m_tvalid rises. One transaction per
//   cycle flows while m_tready is high; the back stage updates all per-transaction state.
// Reset: aresetn low clears all tracking state and empties the pipeline; the
//   configuration returns to goal 1500 ml, tolerance 500 cg, delta 200 cg.
// Stall: while m_tready is low the result holds; up to five transactions are buffered
//   inside, after which s_tready drops until the receiver drains the output.
module cup_weight_drink_tracker_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cwdt_pkg::W_S_TDATA-1:0]      s_tdata,  // [24:0] weight_cg
    input  logic [cwdt_pkg::W_KIND-1:0]         s_tuser,  // [2:0] kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] scale_ready, [1] cup_present, [25:2] water level, [49:26] session_consumed_cg,
    // [76:50] today_total_cg, [95:77] remaining_cg, [96] goal_met, [120:97] drink_cg
    output logic [cwdt_pkg::W_M_TDATA-1:0]      m_tdata,
    output logic [cwdt_pkg::W_EV-1:0]           m_tuser,  // [2:0] event_res
    input  logic                                cfg_wr_en,
    input  logic [cwdt_pkg::W_CFG_IDX-1:0]      cfg_idx,
    input  logic [cwdt_pkg::W_CFG_DATA-1:0]     cfg_wdata
);

    cwdt_pkg::cfg_t   cfg_reg;
    cwdt_pkg::item_t  fr_item;
    cwdt_pkg::item_t  q_item;
    cwdt_pkg::exec_t  ex_res;
    logic             fr_valid;
    logic             fr_ready;
    logic             q_valid;
    logic             q_ready;
    logic             ex_valid;
    logic             ex_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.goal_ml   <= cwdt_pkg::GOAL_DEFAULT;
            cfg_reg.tol_cg    <= cwdt_pkg::TOL_RESET;
            cfg_reg.jitter_cg <= cwdt_pkg::DELTA_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx)
                cwdt_pkg::CFG_GOAL:  cfg_reg.goal_ml   <= cfg_wdata[cwdt_pkg::W_GOAL-1:0];
                cwdt_pkg::CFG_TOL:   cfg_reg.tol_cg    <= cfg_wdata[cwdt_pkg::W_TOL-1:0];
                cwdt_pkg::CFG_DELTA: cfg_reg.jitter_cg <= cfg_wdata[cwdt_pkg::W_DELTA-1:0];
                default: begin
                end
            endcase
        end
    end

    cwdt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .kind      (s_tuser),
        .weight    ($signed(s_tdata[cwdt_pkg::W_WEIGHT-1:0])),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    cwdt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    cwdt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tol_cg    (cfg_reg.tol_cg),
        .jitter_cg (cfg_reg.jitter_cg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (ex_valid),
        .out_ready (ex_ready),
        .out_res   (ex_res)
    );

    cwdt_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .goal_ml  (cfg_reg.goal_ml),
        .in_valid (ex_valid),
        .in_ready (ex_ready),
        .in_res   (ex_res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[tb/tb_cup_weight_drink_tracker_unit.sv]
// Self-checking testbench of the cup weight drink tracker: directed and random scale events.
module tb_cup_weight_drink_tracker_unit;
    import cwdt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [W_KIND-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [W_KIND-1:0] KIND_SPARE_HI = 3'd7;
    localparam int WEIGHT_TOP = 16777215;
    localparam int WEIGHT_BOTTOM = -16777216;

    typedef struct packed {
        logic               scale_ready;
        logic               cup_present;
        logic [W_LEVEL-1:0] water;
        logic [W_LEVEL-1:0] consumed;
        logic [W_TOTAL-1:0] total;
        logic [W_REM-1:0]   remaining;
        logic               goal_met;
        logic [W_EV-1:0]    ev;
        logic [W_LEVEL-1:0] drink;
    } status_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [W_S_TDATA-1:0]  s_tdata = '0;
    logic [W_KIND-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [W_M_TDATA-1:0]  m_tdata;
    logic [W_EV-1:0]       m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [W_CFG_IDX-1:0]  cfg_idx = '0;
    logic [W_CFG_DATA-1:0] cfg_wdata = '0;

    cup_weight_drink_tracker_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // tracker copy
    logic [W_GOAL-1:0]          goal_reg;
    logic [W_TOL-1:0]           tol_reg;
    logic [W_DELTA-1:0]         delta_reg;
    logic [W_TARE-1:0]          tare_q;
    bit                         tare_ok;
    logic signed [W_WEIGHT-1:0] base_q;
    bit                         base_ok;
    logic signed [W_WEIGHT-1:0] last_q;
    bit                         read_ok;
    logic [W_LEVEL-1:0]         cand_q;
    bit                         cand_ok;
    logic [W_CNT-1:0]           cnt_q;
    logic [W_LEVEL-1:0]         stab_q;
    bit                         stab_ok;
    logic [W_TOTAL-1:0]         total_q;

    status_t status_q[$];
    int      err_cnt = 0;
    int      n_items = 0;
    int      n_results = 0;
    int      n_phases = 0;
    int      ev_seen[8];
    int      cycle_cnt = 0;
    bit      burst = 1'b0;
    int      hold_cnt = 0;
    int      rx_roll;

    function automatic bit cup_on_scale();
        longint thr;
        thr = longint'(tare_q) - longint'(tol_reg);
        if (thr < 0) thr = 0;
        return tare_ok && read_ok && (longint'(last_q) >= thr);
    endfunction

    function automatic longint level_now();
        longint v;
        if (!cup_on_scale()) return 0;
        v = longint'(last_q) - longint'(tare_q);
        if (v < 0) v = 0;
        if (v > longint'(LEVEL_MAX)) v = longint'(LEVEL_MAX);
        return v;
    endfunction

    function automatic status_t track_scale_event(input logic [W_KIND-1:0] kind,
                                                  input logic signed [W_WEIGHT-1:0] w);
        status_t s;
        longint  wl, lvl, dlt, d, drink, cons, goal, rem, cand_l, stab_l, tot_l;
        logic [W_EV-1:0] ev;
        wl = longint'(w);
        ev = EV_NONE;
        drink = 0;
        dlt = longint'(delta_reg);
        case (kind)
            KIND_SAMPLE: begin
                read_ok = 1'b1;
                last_q = w;
                if (cup_on_scale()) begin
                    lvl = level_now();
                    cand_l = longint'(cand_q);
                    if (!cand_ok || ((lvl - cand_l < 0) ? cand_l - lvl : lvl - cand_l) > dlt) begin
                        cand_q = W_LEVEL'(lvl);
                        cand_ok = 1'b1;
                        cnt_q = 2'd1;
                    end else begin
                        if (cnt_q < STABLE_SAMPLES) cnt_q = cnt_q + 2'd1;
                        if (cnt_q >= STABLE_SAMPLES) begin
                            if (!stab_ok) begin
                                stab_q = cand_q;
                                stab_ok = 1'b1;
                                ev = EV_FIRST;
                            end else begin
                                stab_l = longint'(stab_q);
                                d = stab_l - cand_l;
                                if (((d < 0) ? -d : d) > dlt) begin
                                    stab_q = cand_q;
                                    if (d > 0) begin
                                        tot_l = longint'(total_q) + d;
                                        if (tot_l > longint'(TOTAL_MAX)) tot_l = longint'(TOTAL_MAX);
                                        total_q = W_TOTAL'(tot_l);
                                        drink = d;
                                        ev = EV_DRINK;
                                    end else begin
                                        ev = EV_REFILL;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            KIND_FAIL: read_ok = 1'b0;
            KIND_CUP: begin
                if (wl < longint'(CUP_MIN_CG) || wl > longint'(CUP_MAX_CG)) begin
                    ev = EV_REJECT;
                end else begin
                    read_ok = 1'b1;
                    tare_ok = 1'b1;
                    tare_q = w[W_TARE-1:0];
                    base_ok = 1'b0;
                    base_q = '0;
                    last_q = w;
                    cand_q = '0;
                    cand_ok = 1'b1;
                    cnt_q = STABLE_SAMPLES;
                    stab_q = '0;
                    stab_ok = 1'b1;
                end
            end
            KIND_BASE: begin
                if (!tare_ok) begin
                    ev = EV_REJECT;
                end else begin
                    read_ok = 1'b1;
                    base_ok = 1'b1;
                    base_q = w;
                    last_q = w;
                    lvl = level_now();
                    cand_q = W_LEVEL'(lvl);
                    cand_ok = 1'b1;
                    cnt_q = STABLE_SAMPLES;
                    stab_q = W_LEVEL'(lvl);
                    stab_ok = 1'b1;
                end
            end
            KIND_DAY: begin
                total_q = '0;
                stab_q = '0;
                stab_ok = 1'b0;
                cand_q = '0;
                cand_ok = 1'b0;
                cnt_q = '0;
            end
            default: ;
        endcase

        lvl = level_now();
        cons = 0;
        if (base_ok) begin
            if (tare_ok) begin
                cons = longint'(base_q) - longint'(tare_q);
                if (cons < 0) cons = 0;
                cons = cons - lvl;
            end else begin
                cons = longint'(base_q) - longint'(last_q);
            end
            if (cons < 0) cons = 0;
            if (cons > longint'(LEVEL_MAX)) cons = longint'(LEVEL_MAX);
        end
        goal = (goal_reg == '0) ? longint'(GOAL_DEFAULT) : longint'(goal_reg);
        if (goal > longint'(GOAL_MAX)) goal = longint'(GOAL_MAX);
        goal = goal * longint'(CG_PER_ML);
        rem = goal - longint'(total_q);
        if (rem < 0) rem = 0;

        s.scale_ready = read_ok;
        s.cup_present = cup_on_scale();
        s.water       = W_LEVEL'(lvl);
        s.consumed    = W_LEVEL'(cons);
        s.total       = total_q;
        s.remaining   = W_REM'(rem);
        s.goal_met    = longint'(total_q) >= goal;
        s.ev          = ev;
        s.drink       = W_LEVEL'(drink);
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_scale(input logic [W_KIND-1:0] kind, input int weight);
        logic signed [W_WEIGHT-1:0] w;
        int gap;
        w = weight[W_WEIGHT-1:0];
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(W_S_TDATA-W_WEIGHT){1'b0}}, w};
        do @(posedge aclk); while (!s_tready);
        status_q.push_back(track_scale_event(kind, w));
        n_items++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value[W_CFG_DATA-1:0];
        case (idx)
            CFG_GOAL:  goal_reg  = value[W_GOAL-1:0];
            CFG_TOL:   tol_reg   = value[W_TOL-1:0];
            CFG_DELTA: delta_reg = value[W_DELTA-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_setting(input int goal, input int tol, input int dlt);
        wait_idle();
        write_reg(CFG_GOAL, goal);
        write_reg(CFG_TOL, tol);
        write_reg(CFG_DELTA, dlt);
        n_phases++;
    endtask

    task automatic test_directed();
        send_scale(KIND_SAMPLE, 1000);
        send_scale(KIND_BASE, 5000);
        send_scale(KIND_CUP, 99);
        send_scale(KIND_CUP, 500001);
        send_scale(KIND_CUP, WEIGHT_BOTTOM);
        send_scale(KIND_CUP, 100);
        send_scale(KIND_CUP, 500000);
        send_scale(KIND_BASE, 30000);
        send_scale(KIND_CUP, 25000);
        send_scale(KIND_BASE, 65000);
        send_scale(KIND_SAMPLE, 64950);
        send_scale(KIND_SAMPLE, 65100);
        repeat (3) send_scale(KIND_SAMPLE, 45000);
        repeat (3) send_scale(KIND_SAMPLE, 85000);
        send_scale(KIND_FAIL, 0);
        send_scale(KIND_SPARE_LO, 12345);
        send_scale(KIND_SPARE_HI, -1);
        send_scale(KIND_SAMPLE, WEIGHT_TOP);
        send_scale(KIND_SAMPLE, WEIGHT_BOTTOM);
        send_scale(KIND_SAMPLE, 24500);
        send_scale(KIND_SAMPLE, 24499);
        send_scale(KIND_DAY, 0);
    endtask

    // eleven full-scale drinks push the day total into saturation
    task automatic test_total_saturation();
        burst = 1'b1;
        send_scale(KIND_CUP, 100);
        repeat (11) begin
            repeat (3) send_scale(KIND_SAMPLE, WEIGHT_TOP);
            repeat (3) send_scale(KIND_SAMPLE, 100);
        end
        send_scale(KIND_DAY, 0);
        burst = 1'b0;
    endtask

    task automatic run_sessions(input int count);
        int sent, tare, lvl, j, wt, r, dlt;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 7) begin
                r = $urandom_range(0, 19);
                if (r == 0)      tare = 100;
                else if (r == 1) tare = 500000;
                else if (r < 5)  tare = $urandom_range(100, 500000);
                else             tare = $urandom_range(5000, 60000);
                send_scale(KIND_CUP, tare);
                sent++;
                if ($urandom_range(0, 1) == 1) begin
                    send_scale(KIND_BASE, tare + $urandom_range(0, 60000));
                    sent++;
                end
                repeat ($urandom_range(2, 6)) begin
                    if ($urandom_range(0, 9) == 0) lvl = $urandom_range(0, WEIGHT_TOP);
                    else                           lvl = $urandom_range(0, 60000);
                    dlt = int'(delta_reg);
                    repeat ($urandom_range(2, 5)) begin
                        j = $urandom_range(0, dlt) - dlt / 2;
                        wt = tare + lvl + j;
                        if (wt > WEIGHT_TOP) wt = WEIGHT_TOP;
                        send_scale(KIND_SAMPLE, wt);
                        sent++;
                    end
                    r = $urandom_range(0, 19);
                    if (r == 0) begin
                        send_scale(KIND_FAIL, $urandom());
                        sent++;
                    end else if (r == 1) begin
                        send_scale(KIND_DAY, $urandom());
                        sent++;
                    end else if (r == 2) begin
                        send_scale(KIND_SAMPLE, $urandom_range(0, tare));
                        sent++;
                    end else if (r == 3) begin
                        send_scale(KIND_BASE, tare + lvl);
                        sent++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    r = $urandom_range(0, 2);
                    if (r == 0)      wt = $urandom();
                    else if (r == 1) wt = $urandom_range(0, 601000) - 1000;
                    else             wt = $urandom_range(0, 20000000) - 1000000;
                    send_scale(W_KIND'($urandom_range(0, 7)), wt);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_config_sweep();
        int goals[5] = '{1500, 0, 8191, 250, 5000};
        int tols[5]  = '{500, 0, 16383, 10000, 0};
        int dlts[5]  = '{200, 0, 16383, 10000, 200};
        for (int i = 0; i < 8; i++) begin
            if (i < 5) apply_setting(goals[i], tols[i], dlts[i]);
            else apply_setting($urandom_range(0, 8191), $urandom_range(0, 16383),
                               $urandom_range(0, 16383));
            burst = (i == 3);
            run_sessions(205);
            burst = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: result %0d %s mismatch: expected %0d actual %0d",
                     $time, n_results, name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, status_q.size());
            $display("tb_cup_weight_drink_tracker_unit: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        status_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_q.size() == 0) begin
                $display("%0t: unexpected result transaction tdata %h tuser %0d",
                         $time, m_tdata, m_tuser);
                err_cnt++;
            end else begin
                e = status_q.pop_front();
                check_field("scale_ready", 64'(e.scale_ready), 64'(m_tdata[0]));
                check_field("cup_present", 64'(e.cup_present), 64'(m_tdata[1]));
                check_field("water", 64'(e.water), 64'(m_tdata[25:2]));
                check_field("session_consumed_cg", 64'(e.consumed), 64'(m_tdata[49:26]));
                check_field("today_total_cg", 64'(e.total), 64'(m_tdata[76:50]));
                check_field("remaining_cg", 64'(e.remaining), 64'(m_tdata[95:77]));
                check_field("goal_met", 64'(e.goal_met), 64'(m_tdata[96]));
                check_field("event_res", 64'(e.ev), 64'(m_tuser));
                check_field("drink_cg", 64'(e.drink), 64'(m_tdata[120:97]));
                ev_seen[e.ev]++;
            end
            n_results++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (burst) begin
            m_tready <= 1'b1;
            hold_cnt = 0;
        end else if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 55) begin
                m_tready <= 1'b1;
            end else if (rx_roll < 92) begin
                m_tready <= 1'b0;
                hold_cnt = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                hold_cnt = $urandom_range(8, 40);
            end
        end
    end

    initial begin
        goal_reg  = GOAL_DEFAULT;
        tol_reg   = TOL_RESET;
        delta_reg = DELTA_RESET;
        tare_q = '0;  tare_ok = 1'b0;
        base_q = '0;  base_ok = 1'b0;
        last_q = '0;  read_ok = 1'b0;
        cand_q = '0;  cand_ok = 1'b0;  cnt_q = '0;
        stab_q = '0;  stab_ok = 1'b0;
        total_q = '0;
        foreach (ev_seen[i]) ev_seen[i] = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_directed();
        test_total_saturation();
        test_config_sweep();
        wait_idle();

        $display("covered %0d scale transactions over %0d register settings",
                 n_items, n_phases);
        $display("events: %0d drinks, %0d refills, %0d first levels, %0d rejects",
                 ev_seen[EV_DRINK], ev_seen[EV_REFILL], ev_seen[EV_FIRST],
                 ev_seen[EV_REJECT]);
        if (err_cnt == 0 && status_q.size() == 0) begin
            $display("tb_cup_weight_drink_tracker_unit: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", err_cnt, status_q.size());
            $display("tb_cup_weight_drink_tracker_unit: FAIL");
        end
        $finish;
    end

endmodule
